// File: hw/rtl/nsrm_pkg.sv
// Shared types and constants of the n-step replay memory.
`default_nettype none
package nsrm_pkg;
  localparam int MEMORY_DEPTH_DEF = 1024;
  localparam int MAX_NSTEP_DEF = 8;
  localparam int OP_W = 2;
  localparam int HW = 16;
  localparam int RW_IN = 32;
  localparam int RW = 36;
  localparam int RAND_W = 10;
  localparam int SIZE_W = 11;
  localparam int NSTEP_W = 4;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic CFG_SIZE = 1'b0;
  localparam logic CFG_NSTEP = 1'b1;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [HW-1:0] graph;
    logic [HW-1:0] state;
    logic [HW-1:0] action;
    logic signed [RW_IN-1:0] reward;
    logic episode_end;
    logic [HW-1:0] final_h;
    logic [RAND_W-1:0] rnd;
  } cmd_t;

  typedef struct packed {
    logic [HW-1:0] graph;
    logic [HW-1:0] state;
    logic [HW-1:0] action;
    logic signed [RW-1:0] reward;
    logic [HW-1:0] next;
    logic terminal;
  } entry_t;

  localparam int ENTRY_W = 3 * HW + RW + HW + 1;
endpackage
`default_nettype wire

// File: hw/rtl/nsrm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module nsrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/nsrm_front.sv
// Front end: accepts items, classifies them and queues commands.
`default_nettype none
module nsrm_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_push,
  output logic                           in_full,
  input  wire logic [nsrm_pkg::OP_W-1:0] in_op,
  input  wire logic [nsrm_pkg::HW-1:0]   in_graph_handle,
  input  wire logic [nsrm_pkg::HW-1:0]   in_state_handle,
  input  wire logic [nsrm_pkg::HW-1:0]   in_action,
  input  wire logic signed [nsrm_pkg::RW_IN-1:0] in_reward,
  input  wire logic                      in_episode_end,
  input  wire logic [nsrm_pkg::HW-1:0]   in_final_handle,
  input  wire logic [nsrm_pkg::RAND_W-1:0] in_random_value,
  output logic                           q_valid,
  output nsrm_pkg::cmd_t                 q_cmd,
  input  wire logic                      q_take
);
  nsrm_pkg::cmd_t buf_r [2];
  logic rd_r, wr_r;
  logic [1:0] cnt_r;
  logic acc, useful;
  nsrm_pkg::cmd_t c;

  assign in_full = (cnt_r == 2'd2);
  assign useful = (in_op == nsrm_pkg::OP_PUSH) || (in_op == nsrm_pkg::OP_SAMPLE) ||
                  (in_op == nsrm_pkg::OP_CLEAR);
  assign acc = in_push && !in_full && useful;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = buf_r[rd_r];

  always_comb begin
    c.cmd = nsrm_pkg::CMD_PUSH;
    unique case (in_op)
      nsrm_pkg::OP_SAMPLE: c.cmd = nsrm_pkg::CMD_SAMPLE;
      nsrm_pkg::OP_CLEAR: c.cmd = nsrm_pkg::CMD_CLEAR;
      default: c.cmd = nsrm_pkg::CMD_PUSH;
    endcase
    c.graph = in_graph_handle;
    c.state = in_state_handle;
    c.action = in_action;
    c.reward = in_reward;
    c.episode_end = in_episode_end;
    c.final_h = in_final_handle;
    c.rnd = in_random_value;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      buf_r[wr_r] <= c;
    end
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (acc) wr_r <= ~wr_r;
      if (q_take) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, acc} - {1'b0, q_take};
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/nsrm_back.sv
// Back end: n-step window, ring commits, modulo sampling and result register.
`default_nettype none
module nsrm_back #(
  parameter int MEMORY_DEPTH = nsrm_pkg::MEMORY_DEPTH_DEF,
  parameter int MAX_NSTEP = nsrm_pkg::MAX_NSTEP_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [nsrm_pkg::SIZE_W-1:0]  cfg_wdata,
  input  wire logic                         q_valid,
  input  wire nsrm_pkg::cmd_t               q_cmd,
  output logic                              q_take,
  output logic                              out_empty,
  input  wire logic                         out_pop,
  output nsrm_pkg::entry_t                  out_entry,
  output logic                              out_err
);
  localparam int AW = $clog2(MEMORY_DEPTH);
  localparam int CW = $clog2(MEMORY_DEPTH + 1);
  localparam int WW = (MAX_NSTEP > 1) ? $clog2(MAX_NSTEP) : 1;
  localparam int NW = $clog2(MAX_NSTEP + 1);
  localparam int RW = nsrm_pkg::RW;
  localparam int RAND_W_L = nsrm_pkg::RAND_W;
  localparam int BW = $clog2(RAND_W_L + 1);
  localparam logic signed [RW:0] R36_MAX = {2'b00, {(RW-1){1'b1}}};
  localparam logic signed [RW:0] R36_MIN = {2'b11, {(RW-1){1'b0}}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM = 3'd1;
  localparam logic [2:0] S_COMMIT = 3'd2;
  localparam logic [2:0] S_DIV = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;
  localparam logic [2:0] S_DATA = 3'd5;

  logic [2:0] st_r;
  logic [nsrm_pkg::SIZE_W-1:0] size_cfg_r;
  logic [nsrm_pkg::NSTEP_W-1:0] n_cfg_r;
  logic [AW-1:0] wp_r;
  logic [CW-1:0] fill_r;
  logic [nsrm_pkg::HW-1:0] wst_r [MAX_NSTEP];
  logic [nsrm_pkg::HW-1:0] wact_r [MAX_NSTEP];
  logic signed [nsrm_pkg::RW_IN-1:0] wrew_r [MAX_NSTEP];
  logic [WW-1:0] head_r;
  logic [NW-1:0] cnt_r;
  logic [nsrm_pkg::HW-1:0] egraph_r;
  nsrm_pkg::cmd_t cur_r;
  logic flush_r;
  logic [NW-1:0] k_r, klim_r;
  logic signed [RW:0] sum_r;
  logic [CW-1:0] rem_r;
  logic [RAND_W_L-1:0] rbits_r;
  logic [BW-1:0] bit_r;
  logic out_v_r, out_err_r;
  nsrm_pkg::entry_t out_r;

  logic [CW-1:0] ring;
  logic [NW-1:0] look_n;
  logic [WW-1:0] slot_k, slot_n, slot_cnt;
  logic ram_we;
  logic [AW-1:0] ram_raddr;
  logic [nsrm_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  nsrm_pkg::entry_t wentry;
  logic signed [RW:0] sat;
  logic [CW:0] rem_sh;

  function automatic logic [WW-1:0] wslot(input logic [WW-1:0] h, input logic [NW-1:0] k);
    logic [NW+WW:0] s;
    s = {{(NW+1){1'b0}}, h} + {{(WW+1){1'b0}}, k};
    if (MAX_NSTEP > 1 && (MAX_NSTEP & (MAX_NSTEP - 1)) == 0) begin
      wslot = s[WW-1:0];
    end else begin
      if (s >= (NW+WW+1)'(MAX_NSTEP)) s = s - (NW+WW+1)'(MAX_NSTEP);
      wslot = s[WW-1:0];
    end
  endfunction

  always_comb begin
    if (size_cfg_r == '0) ring = CW'(1);
    else if (32'(size_cfg_r) > 32'(MEMORY_DEPTH)) ring = CW'(MEMORY_DEPTH);
    else ring = CW'(size_cfg_r);
    if (n_cfg_r == '0) look_n = NW'(1);
    else if (32'(n_cfg_r) > 32'(MAX_NSTEP)) look_n = NW'(MAX_NSTEP);
    else look_n = NW'(n_cfg_r);
  end

  assign slot_k = wslot(head_r, k_r);
  assign slot_n = wslot(head_r, look_n);
  assign slot_cnt = wslot(head_r, cnt_r);

  always_comb begin
    if (sum_r > R36_MAX) sat = R36_MAX;
    else if (sum_r < R36_MIN) sat = R36_MIN;
    else sat = sum_r;
    wentry.graph = egraph_r;
    wentry.state = wst_r[head_r];
    wentry.action = wact_r[head_r];
    wentry.reward = sat[RW-1:0];
    wentry.terminal = flush_r;
    if (flush_r) wentry.next = cur_r.final_h;
    else if (cnt_r > look_n) wentry.next = wst_r[slot_n];
    else wentry.next = cur_r.state;
  end

  assign ram_wdata = wentry;
  assign ram_we = (st_r == S_COMMIT);
  assign ram_raddr = rem_r[AW-1:0];
  assign rem_sh = {rem_r, rbits_r[RAND_W_L-1]};

  nsrm_ram #(.WIDTH(nsrm_pkg::ENTRY_W), .DEPTH(MEMORY_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(wp_r), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign out_empty = !out_v_r;
  assign out_entry = out_r;
  assign out_err = out_err_r;
  assign q_take = (st_r == S_IDLE) && q_valid && !out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      size_cfg_r <= nsrm_pkg::SIZE_W'(1024);
      n_cfg_r <= nsrm_pkg::NSTEP_W'(1);
      wp_r <= '0;
      fill_r <= '0;
      head_r <= '0;
      cnt_r <= '0;
      egraph_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == nsrm_pkg::CFG_SIZE) size_cfg_r <= cfg_wdata;
        else n_cfg_r <= cfg_wdata[nsrm_pkg::NSTEP_W-1:0];
      end
      if (out_pop && out_v_r) out_v_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (q_take) begin
            cur_r <= q_cmd;
            unique case (q_cmd.cmd)
              nsrm_pkg::CMD_CLEAR: begin
                wp_r <= '0;
                fill_r <= '0;
              end
              nsrm_pkg::CMD_SAMPLE: begin
                if (fill_r == '0) begin
                  out_v_r <= 1'b1;
                  out_err_r <= 1'b1;
                  out_r <= '0;
                end else begin
                  rem_r <= '0;
                  rbits_r <= q_cmd.rnd;
                  bit_r <= '0;
                  st_r <= S_DIV;
                end
              end
              default: begin
                if (cnt_r == '0) egraph_r <= q_cmd.graph;
                k_r <= '0;
                sum_r <= '0;
                flush_r <= (cnt_r < look_n) && q_cmd.episode_end;
                if (cnt_r >= look_n) begin
                  klim_r <= look_n;
                  st_r <= S_SUM;
                end else begin
                  wst_r[slot_cnt] <= q_cmd.state;
                  wact_r[slot_cnt] <= q_cmd.action;
                  wrew_r[slot_cnt] <= q_cmd.reward;
                  cnt_r <= cnt_r + NW'(1);
                  klim_r <= cnt_r + NW'(1);
                  if (q_cmd.episode_end) st_r <= S_SUM;
                end
              end
            endcase
          end
        end
        S_SUM: begin
          if (k_r == klim_r) st_r <= S_COMMIT;
          else begin
            sum_r <= sum_r + (RW+1)'(wrew_r[slot_k]);
            k_r <= k_r + NW'(1);
          end
        end
        S_COMMIT: begin
          if ({1'b0, wp_r} + (AW+1)'(1) > (AW+1)'(fill_r)) fill_r <= CW'(wp_r) + CW'(1);
          if (CW'(wp_r) + CW'(1) >= ring) wp_r <= '0;
          else wp_r <= wp_r + AW'(1);
          k_r <= '0;
          sum_r <= '0;
          if (flush_r) begin
            cnt_r <= cnt_r - NW'(1);
            klim_r <= cnt_r - NW'(1);
            if (cnt_r == NW'(1)) begin
              head_r <= '0;
              st_r <= S_IDLE;
            end else begin
              head_r <= wslot(head_r, NW'(1));
              st_r <= S_SUM;
            end
          end else begin
            head_r <= wslot(head_r, NW'(1));
            if (cnt_r - NW'(1) >= look_n) begin
              cnt_r <= cnt_r - NW'(1);
              st_r <= S_SUM;
            end else begin
              wst_r[wslot(head_r, cnt_r)] <= cur_r.state;
              wact_r[wslot(head_r, cnt_r)] <= cur_r.action;
              wrew_r[wslot(head_r, cnt_r)] <= cur_r.reward;
              if (cur_r.episode_end) begin
                flush_r <= 1'b1;
                klim_r <= cnt_r;
                st_r <= S_SUM;
              end else st_r <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          if (bit_r == BW'(RAND_W_L)) st_r <= S_READ;
          else begin
            if (rem_sh >= {1'b0, fill_r}) rem_r <= CW'(rem_sh - {1'b0, fill_r});
            else rem_r <= CW'(rem_sh);
            rbits_r <= {rbits_r[RAND_W_L-2:0], 1'b0};
            bit_r <= bit_r + BW'(1);
          end
        end
        S_READ: st_r <= S_DATA;
        S_DATA: begin
          out_v_r <= 1'b1;
          out_err_r <= 1'b0;
          out_r <= ram_rdata;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) fill_r <= CW'(MEMORY_DEPTH))
    else $error("fill count beyond depth");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= NW'(MAX_NSTEP))
    else $error("window overfilled");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DATA) |-> !out_v_r) else $error("result overwritten");
endmodule
`default_nettype wire

// File: hw/rtl/nstep_replay_memory_core.sv
// Top level of the n-step replay memory.
// Push without commit fills the window; each commit sums the window and writes the RAM,
// an episode end flushes up to n entries with a summing pass each through the window adder.
// Sample: bit-serial modulo unit, then the registered RAM read. Clear: resets write pointer
// and fill count. One item is worked at a time; a 2-entry queue decouples the input.
// Synchronous active-low reset clears pointers, counts and queues; the store is not cleared.
`default_nettype none
module nstep_replay_memory_core #(
  parameter int MEMORY_DEPTH = nsrm_pkg::MEMORY_DEPTH_DEF,
  parameter int MAX_NSTEP = nsrm_pkg::MAX_NSTEP_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [10:0] cfg_wdata,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_op,
  input  wire logic [15:0] in_graph_handle,
  input  wire logic [15:0] in_state_handle,
  input  wire logic [15:0] in_action,
  input  wire logic signed [31:0] in_reward,
  input  wire logic        in_episode_end,
  input  wire logic [15:0] in_final_handle,
  input  wire logic [9:0]  in_random_value,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      out_sampled_graph,
  output logic [15:0]      out_sampled_state,
  output logic [15:0]      out_sampled_action,
  output logic signed [35:0] out_sampled_reward,
  output logic [15:0]      out_sampled_next,
  output logic             out_sampled_terminal,
  output logic             out_empty_error
);
  logic q_valid, q_take;
  nsrm_pkg::cmd_t q_cmd;
  nsrm_pkg::entry_t ent;

  nsrm_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(push), .in_full(full), .in_op(in_op),
    .in_graph_handle(in_graph_handle), .in_state_handle(in_state_handle),
    .in_action(in_action), .in_reward(in_reward), .in_episode_end(in_episode_end),
    .in_final_handle(in_final_handle), .in_random_value(in_random_value),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take)
  );

  nsrm_back #(.MEMORY_DEPTH(MEMORY_DEPTH), .MAX_NSTEP(MAX_NSTEP)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take),
    .out_empty(empty), .out_pop(pop), .out_entry(ent), .out_err(out_empty_error)
  );

  assign out_sampled_graph = ent.graph;
  assign out_sampled_state = ent.state;
  assign out_sampled_action = ent.action;
  assign out_sampled_reward = ent.reward;
  assign out_sampled_next = ent.next;
  assign out_sampled_terminal = ent.terminal;
endmodule
`default_nettype wire
